// ===== src/limit_order_book_matcher_top_macros.svh =====
// Assertion macros for the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i outside reset.
`define LOBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("order book matcher check failed");
// Next-cycle implication, sampled on clk_i outside reset.
`define LOBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("order book matcher check failed");
`else
`define LOBM_ASSERT_IMP(lbl, ante, cons)
`define LOBM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/lobm_pkg.sv =====
// Shared constants and types of the order book matcher.
`default_nettype none
package lobm_pkg;

  localparam int ORDER_SLOTS = 16;
  localparam int SLOT_IW     = $clog2(ORDER_SLOTS);
  localparam int SLOT_CW     = $clog2(ORDER_SLOTS + 1);

  localparam int PRICE_W = 23;
  localparam int QTY_W   = 20;
  localparam int OWNER_W = 16;
  localparam int OID_W   = 32;
  localparam int ARR_W   = 32;
  localparam int TIME_W  = 63;
  localparam int TICK_W  = 16;
  localparam int TGT_W   = PRICE_W + 2;

  localparam logic [QTY_W-1:0] QTY_MAX = '1;

  // Message function codes.
  localparam logic [1:0] FUNC_LIMIT  = 2'd0;
  localparam logic [1:0] FUNC_MARKET = 2'd1;
  localparam logic [1:0] FUNC_COWNER = 2'd2;
  localparam logic [1:0] FUNC_CDIST  = 2'd3;

  // Report kinds.
  localparam logic KIND_FILL   = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  // One resting order as held in the slot memory.
  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [OWNER_W-1:0] owner;
    logic [OID_W-1:0]   oid;
    logic [ARR_W-1:0]   arrival;
  } slot_t;

  // One outgoing report word.
  typedef struct packed {
    logic               kind;
    logic [OWNER_W-1:0] owner;
    logic [OID_W-1:0]   oid;
    logic [1:0]         action;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [QTY_W-1:0]   executed;
    logic [QTY_W-1:0]   resting;
    logic [QTY_W-1:0]   cancelled;
    logic [TIME_W-1:0]  rtime;
    logic               last;
  } rep_t;

endpackage
`default_nettype wire

// ===== src/lobm_if.sv =====
// Valid/ready channel interfaces for order messages and reports.
`default_nettype none
interface lobm_ord_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic                          side;
  logic signed [20:0]            quantity;
  logic signed [23:0]            price;
  logic [lobm_pkg::OWNER_W-1:0]  owner;
  logic [lobm_pkg::OID_W-1:0]    msg_seq;
  logic                          institutional;
  logic signed [7:0]             distance;
  logic [lobm_pkg::TIME_W-1:0]   timestamp;

  modport source (output valid, func, side, quantity, price, owner, msg_seq,
                  institutional, distance, timestamp, input ready);
  modport sink (input valid, func, side, quantity, price, owner, msg_seq,
                institutional, distance, timestamp, output ready);
endinterface

interface lobm_rep_if;
  logic                          valid;
  logic                          ready;
  logic                          report_kind;
  logic [lobm_pkg::OWNER_W-1:0]  rep_owner;
  logic [lobm_pkg::OID_W-1:0]    rep_order_id;
  logic [1:0]                    rep_action;
  logic                          rep_side;
  logic [lobm_pkg::PRICE_W-1:0]  fill_price;
  logic [lobm_pkg::QTY_W-1:0]    fill_or_requested_qty;
  logic [lobm_pkg::QTY_W-1:0]    executed_qty;
  logic [lobm_pkg::QTY_W-1:0]    resting_qty;
  logic [lobm_pkg::QTY_W-1:0]    cancelled_qty;
  logic [lobm_pkg::TIME_W-1:0]   rep_time;
  logic                          last;

  modport source (output valid, report_kind, rep_owner, rep_order_id, rep_action,
                  rep_side, fill_price, fill_or_requested_qty, executed_qty,
                  resting_qty, cancelled_qty, rep_time, last, input ready);
  modport sink (input valid, report_kind, rep_owner, rep_order_id, rep_action,
                rep_side, fill_price, fill_or_requested_qty, executed_qty,
                resting_qty, cancelled_qty, rep_time, last, output ready);
endinterface
`default_nettype wire

// ===== src/limit_order_book_matcher_top.sv =====
// Top level of the price-time priority order book matcher.
`default_nettype none
`include "limit_order_book_matcher_top_macros.svh"
// The book holds ORDER_SLOTS resting orders in a slot memory with registered
// read, plus a valid flag per slot. One order message is taken at a time, in
// a cycle where the block is idle. Every search of the book (best opposite
// level, best own level, the target level of a cancel-at-distance, or all
// orders of one owner) reads one slot per cycle and is followed by the
// decision state, except for an owner cancel. Each fill of a limit or market
// order passes through a search, the decision, an update state and a state for
// each of its two fill reports, whether or not the reports are sent; a search
// that finds nothing more to take ends the match, and a limit order then rests
// its remainder in a further state. A cancel-at-distance searches once for the
// best level and once for each order it trims, each trim followed by the
// decision and an update, plus a last search when quantity is left over. An
// owner cancel costs one search. Every message also passes through the idle
// state that accepts it, the result report state and the state that hands out
// the final word; a stalled report output holds the sequencer in the report
// states. Reports leave through an output register fed by a one-word holding
// stage, which lets the final word of a message carry last.
// After reset the book is empty and no clearing pass is needed.
module limit_order_book_matcher_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [lobm_pkg::TICK_W-1:0]   cfg_wdata_i,
  lobm_ord_if.sink                      ord_i,
  lobm_rep_if.source                    rep_o
);

  localparam int N  = lobm_pkg::ORDER_SLOTS;
  localparam int IW = lobm_pkg::SLOT_IW;
  localparam int CW = lobm_pkg::SLOT_CW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_DECIDE   = 4'd2;
  localparam logic [3:0] S_APPLY    = 4'd3;
  localparam logic [3:0] S_REP_REST = 4'd4;
  localparam logic [3:0] S_REP_AGG  = 4'd5;
  localparam logic [3:0] S_REST     = 4'd6;
  localparam logic [3:0] S_REP_RES  = 4'd7;
  localparam logic [3:0] S_FLUSH    = 4'd8;

  // Scan purposes.
  localparam logic [1:0] M_MATCH = 2'd0;
  localparam logic [1:0] M_DBEST = 2'd1;
  localparam logic [1:0] M_DTGT  = 2'd2;
  localparam logic [1:0] M_COWN  = 2'd3;

  logic [3:0]                      state_q, state_d;
  logic [1:0]                      mode_q, mode_d;
  logic [CW-1:0]                   sc_q, sc_d;
  logic [lobm_pkg::TICK_W-1:0]     tick_q, tick_d;
  logic [lobm_pkg::ARR_W-1:0]      ctr_q, ctr_d;
  logic [N-1:0]                    valid_q, valid_d;
  logic                            bfound_q, bfound_d;
  logic [IW-1:0]                   bidx_q, bidx_d;
  lobm_pkg::slot_t                 bent_q, bent_d;
  logic                            pend_v_q, pend_v_d;
  lobm_pkg::rep_t                  pend_q, pend_d;
  logic                            out_v_q, out_v_d;
  lobm_pkg::rep_t                  out_q, out_d;

  // Latched message fields and running totals.
  logic [1:0]                      func_q, func_d;
  logic                            side_q, side_d;
  logic [lobm_pkg::QTY_W-1:0]      req_q, req_d;
  logic [lobm_pkg::QTY_W-1:0]      rem_q, rem_d;
  logic [lobm_pkg::QTY_W-1:0]      exec_q, exec_d;
  logic [lobm_pkg::QTY_W-1:0]      canc_q, canc_d;
  logic [lobm_pkg::QTY_W-1:0]      rest_q, rest_d;
  logic [lobm_pkg::QTY_W-1:0]      f_q, f_d;
  logic [lobm_pkg::PRICE_W-1:0]    limit_q, limit_d;
  logic [lobm_pkg::OWNER_W-1:0]    owner_q, owner_d;
  logic [lobm_pkg::OID_W-1:0]      oid_q, oid_d;
  logic                            inst_q, inst_d;
  logic [lobm_pkg::TIME_W-1:0]     time_q, time_d;
  logic [lobm_pkg::PRICE_W-1:0]    step_q, step_d;
  logic signed [lobm_pkg::TGT_W-1:0] target_q, target_d;

  // Slot memory ports.
  lobm_pkg::slot_t                 mem [N];
  lobm_pkg::slot_t                 mem_rd_q;
  logic                            mem_we;
  logic [IW-1:0]                   mem_wa;
  lobm_pkg::slot_t                 mem_wd;
  logic [IW-1:0]                   mem_ra;

  // Helper values.
  logic                            accept;
  logic                            qpos;
  logic [lobm_pkg::TICK_W-1:0]     tick_eff;
  logic [IW-1:0]                   k;
  logic                            ss;
  logic                            cand;
  logic                            better;
  logic [lobm_pkg::ARR_W-1:0]      age_k, age_b;
  logic [lobm_pkg::QTY_W:0]        csum;
  logic                            out_free;
  logic                            want;
  lobm_pkg::rep_t                  rep_new;
  logic                            free_found;
  logic [IW-1:0]                   free_idx;
  logic [lobm_pkg::QTY_W-1:0]      fmin;
  logic                            stop;

  assign accept      = ord_i.valid && ord_i.ready;
  assign ord_i.ready = (state_q == S_IDLE);
  assign qpos        = !ord_i.quantity[20] && (ord_i.quantity != '0);
  assign tick_eff    = (tick_q == '0) ? lobm_pkg::TICK_W'(1) : tick_q;
  assign out_free    = !out_v_q || rep_o.ready;
  assign mem_ra      = (sc_q < CW'(N)) ? sc_q[IW-1:0] : '0;
  assign k           = IW'(sc_q - CW'(1));
  assign ss          = (mode_q == M_MATCH) ? ~side_q : side_q;
  assign age_k       = ctr_q - mem_rd_q.arrival;
  assign age_b       = ctr_q - bent_q.arrival;
  assign csum        = {1'b0, canc_q} + {1'b0, mem_rd_q.qty};
  assign fmin        = (rem_q < bent_q.qty) ? rem_q : bent_q.qty;

  // Candidate test and ordering for the slot now returned by the memory.
  always_comb begin
    cand = valid_q[k] && (mem_rd_q.side == ss) &&
           ((mode_q != M_DTGT) ||
            ($signed({2'b00, mem_rd_q.price}) == target_q));
    if (!bfound_q) begin
      better = 1'b1;
    end else if (mode_q == M_DTGT) begin
      better = age_k < age_b;
    end else if (mem_rd_q.price != bent_q.price) begin
      better = (ss == 1'b0) ? (mem_rd_q.price > bent_q.price)
                            : (mem_rd_q.price < bent_q.price);
    end else begin
      better = age_k > age_b;
    end
  end

  // First free slot for a resting remainder.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Report word offered in the report states.
  always_comb begin
    rep_new       = '0;
    rep_new.rtime = time_q;
    want          = 1'b0;
    case (state_q)
      S_REP_REST: begin
        want           = (bent_q.owner != '0);
        rep_new.kind   = lobm_pkg::KIND_FILL;
        rep_new.owner  = bent_q.owner;
        rep_new.oid    = bent_q.oid;
        rep_new.action = lobm_pkg::FUNC_LIMIT;
        rep_new.side   = bent_q.side;
        rep_new.price  = bent_q.price;
        rep_new.qty    = f_q;
      end
      S_REP_AGG: begin
        want           = (owner_q != '0);
        rep_new.kind   = lobm_pkg::KIND_FILL;
        rep_new.owner  = owner_q;
        rep_new.oid    = oid_q;
        rep_new.action = func_q;
        rep_new.side   = side_q;
        rep_new.price  = bent_q.price;
        rep_new.qty    = f_q;
      end
      S_REP_RES: begin
        want              = (owner_q != '0) && inst_q;
        rep_new.kind      = lobm_pkg::KIND_RESULT;
        rep_new.owner     = owner_q;
        rep_new.oid       = oid_q;
        rep_new.action    = func_q;
        rep_new.side      = side_q;
        rep_new.qty       = req_q;
        rep_new.executed  = exec_q;
        rep_new.resting   = rest_q;
        rep_new.cancelled = canc_q;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    sc_d     = sc_q;
    tick_d   = cfg_we_i ? cfg_wdata_i : tick_q;
    ctr_d    = ctr_q;
    valid_d  = valid_q;
    bfound_d = bfound_q;
    bidx_d   = bidx_q;
    bent_d   = bent_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !rep_o.ready;
    out_d    = out_q;
    func_d   = func_q;
    side_d   = side_q;
    req_d    = req_q;
    rem_d    = rem_q;
    exec_d   = exec_q;
    canc_d   = canc_q;
    rest_d   = rest_q;
    f_d      = f_q;
    limit_d  = limit_q;
    owner_d  = owner_q;
    oid_d    = oid_q;
    inst_d   = inst_q;
    time_d   = time_q;
    step_d   = step_q;
    target_d = target_q;
    stop     = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = bidx_q;
    mem_wd   = bent_q;

    // Place a report into the holding stage, moving the older one out.
    if (want && (!pend_v_q || out_free)) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = rep_new;
      pend_v_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d   = ord_i.func;
          side_d   = ord_i.side;
          owner_d  = ord_i.owner;
          oid_d    = ord_i.msg_seq;
          inst_d   = ord_i.institutional;
          time_d   = ord_i.timestamp;
          limit_d  = ord_i.price[lobm_pkg::PRICE_W-1:0];
          step_d   = lobm_pkg::PRICE_W'(ord_i.distance[6:0]) *
                     lobm_pkg::PRICE_W'(tick_eff);
          rem_d    = ord_i.quantity[lobm_pkg::QTY_W-1:0];
          req_d    = (qpos && (ord_i.func != lobm_pkg::FUNC_COWNER)) ?
                     ord_i.quantity[lobm_pkg::QTY_W-1:0] : '0;
          exec_d   = '0;
          canc_d   = '0;
          rest_d   = '0;
          sc_d     = '0;
          bfound_d = 1'b0;
          state_d  = S_REP_RES;
          case (ord_i.func)
            lobm_pkg::FUNC_LIMIT: begin
              if (qpos && !ord_i.price[23] && (ord_i.price != '0)) begin
                mode_d  = M_MATCH;
                state_d = S_SCAN;
              end
            end
            lobm_pkg::FUNC_MARKET: begin
              if (qpos) begin
                mode_d  = M_MATCH;
                state_d = S_SCAN;
              end
            end
            lobm_pkg::FUNC_COWNER: begin
              if (ord_i.owner != '0) begin
                mode_d  = M_COWN;
                state_d = S_SCAN;
              end
            end
            default: begin
              if (qpos && !ord_i.distance[7]) begin
                mode_d  = M_DBEST;
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end

      // One slot per cycle; data for slot sc-1 arrives while slot sc is read.
      S_SCAN: begin
        sc_d = sc_q + CW'(1);
        if (sc_q != '0) begin
          if (mode_q == M_COWN) begin
            if (valid_q[k] && (mem_rd_q.owner == owner_q)) begin
              canc_d     = csum[lobm_pkg::QTY_W] ? lobm_pkg::QTY_MAX
                                                 : csum[lobm_pkg::QTY_W-1:0];
              valid_d[k] = 1'b0;
            end
          end else if (cand && better) begin
            bfound_d = 1'b1;
            bidx_d   = k;
            bent_d   = mem_rd_q;
          end
        end
        if (sc_q == CW'(N)) begin
          state_d = (mode_q == M_COWN) ? S_REP_RES : S_DECIDE;
        end
      end

      S_DECIDE: begin
        sc_d     = '0;
        bfound_d = 1'b0;
        case (mode_q)
          M_MATCH: begin
            stop = !bfound_q ||
                   ((func_q == lobm_pkg::FUNC_LIMIT) &&
                    ((side_q == 1'b0) ? (bent_q.price > limit_q)
                                      : (bent_q.price < limit_q)));
            if (stop) begin
              state_d = ((func_q == lobm_pkg::FUNC_LIMIT) && (rem_q != '0)) ?
                        S_REST : S_REP_RES;
            end else begin
              f_d     = fmin;
              state_d = S_APPLY;
            end
          end
          M_DBEST: begin
            if (!bfound_q) begin
              state_d = S_REP_RES;
            end else begin
              target_d = (side_q == 1'b0) ?
                         $signed({2'b00, bent_q.price}) - $signed({2'b00, step_q}) :
                         $signed({2'b00, bent_q.price}) + $signed({2'b00, step_q});
              mode_d   = M_DTGT;
              state_d  = S_SCAN;
            end
          end
          default: begin
            if (!bfound_q) begin
              state_d = S_REP_RES;
            end else begin
              f_d     = fmin;
              state_d = S_APPLY;
            end
          end
        endcase
      end

      // Take the fill or cancel out of the chosen slot.
      S_APPLY: begin
        mem_we     = 1'b1;
        mem_wd.qty = bent_q.qty - f_q;
        bent_d.qty = bent_q.qty - f_q;
        if (bent_q.qty == f_q) begin
          valid_d[bidx_q] = 1'b0;
        end
        rem_d = rem_q - f_q;
        sc_d  = '0;
        if (mode_q == M_MATCH) begin
          exec_d  = exec_q + f_q;
          state_d = S_REP_REST;
        end else begin
          canc_d  = canc_q + f_q;
          state_d = (rem_q == f_q) ? S_REP_RES : S_SCAN;
        end
      end

      S_REP_REST: begin
        if (!want || !pend_v_q || out_free) begin
          state_d = S_REP_AGG;
        end
      end

      S_REP_AGG: begin
        if (!want || !pend_v_q || out_free) begin
          sc_d     = '0;
          bfound_d = 1'b0;
          state_d  = (rem_q != '0) ? S_SCAN : S_REP_RES;
        end
      end

      // Rest the remainder of a limit order in the first free slot.
      S_REST: begin
        if (free_found) begin
          mem_we            = 1'b1;
          mem_wa            = free_idx;
          mem_wd.side       = side_q;
          mem_wd.price      = limit_q;
          mem_wd.qty        = rem_q;
          mem_wd.owner      = owner_q;
          mem_wd.oid        = oid_q;
          mem_wd.arrival    = ctr_q;
          valid_d[free_idx] = 1'b1;
          ctr_d             = ctr_q + lobm_pkg::ARR_W'(1);
          rest_d            = rem_q;
        end
        state_d = S_REP_RES;
      end

      S_REP_RES: begin
        if (!want || !pend_v_q || out_free) begin
          state_d = S_FLUSH;
        end
      end

      // Hand the held word out with last set.
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Slot memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= M_MATCH;
      sc_q     <= '0;
      tick_q   <= lobm_pkg::TICK_W'(1);
      ctr_q    <= '0;
      valid_q  <= '0;
      bfound_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      sc_q     <= sc_d;
      tick_q   <= tick_d;
      ctr_q    <= ctr_d;
      valid_q  <= valid_d;
      bfound_q <= bfound_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bidx_q   <= bidx_d;
    bent_q   <= bent_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
    func_q   <= func_d;
    side_q   <= side_d;
    req_q    <= req_d;
    rem_q    <= rem_d;
    exec_q   <= exec_d;
    canc_q   <= canc_d;
    rest_q   <= rest_d;
    f_q      <= f_d;
    limit_q  <= limit_d;
    owner_q  <= owner_d;
    oid_q    <= oid_d;
    inst_q   <= inst_d;
    time_q   <= time_d;
    step_q   <= step_d;
    target_q <= target_d;
  end

  // Report channel drive.
  assign rep_o.valid                 = out_v_q;
  assign rep_o.report_kind           = out_q.kind;
  assign rep_o.rep_owner             = out_q.owner;
  assign rep_o.rep_order_id          = out_q.oid;
  assign rep_o.rep_action            = out_q.action;
  assign rep_o.rep_side              = out_q.side;
  assign rep_o.fill_price            = out_q.price;
  assign rep_o.fill_or_requested_qty = out_q.qty;
  assign rep_o.executed_qty          = out_q.executed;
  assign rep_o.resting_qty           = out_q.resting;
  assign rep_o.cancelled_qty         = out_q.cancelled;
  assign rep_o.rep_time              = out_q.rtime;
  assign rep_o.last                  = out_q.last;

  // A new message is only taken once the held report word has gone out.
  `LOBM_ASSERT_IMP(a_idle_no_pending, ord_i.ready, !pend_v_q)
  // A fill or cancel only updates a slot that holds an order, and the change is not empty.
  `LOBM_ASSERT_IMP(a_apply_has_slot, state_q == S_APPLY, (f_q != '0) && valid_q[bidx_q])
  // The arrival counter moves only when an order comes to rest.
  `LOBM_ASSERT_NXT(a_ctr_only_rest, state_q != S_REST, ctr_q == $past(ctr_q))

endmodule
`default_nettype wire

// ===== tb/limit_order_book_matcher_top_tb.sv =====
// Self-checking testbench for the order book matcher: predicts every report word.
`default_nettype none
module limit_order_book_matcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 6000;
  localparam int DRAIN_WAIT  = 1000;
  localparam int RAND_ITEMS  = 85;
  localparam int SLOTS       = lobm_pkg::ORDER_SLOTS;

  // One order message as offered to the block.
  typedef struct {
    logic [1:0]         func;
    logic               side;
    logic signed [20:0] qty;
    logic signed [23:0] price;
    logic [15:0]        owner;
    logic [31:0]        oid;
    logic               inst;
    logic signed [7:0]  lvl_off;
    logic [62:0]        ts;
  } order_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lobm_pkg::TICK_W-1:0] cfg_wdata_i = '0;

  lobm_ord_if ord_bus ();
  lobm_rep_if rep_bus ();

  limit_order_book_matcher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ord_i       (ord_bus),
    .rep_o       (rep_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted book contents.
  logic                         book_valid [SLOTS];
  logic                         book_side  [SLOTS];
  logic [lobm_pkg::PRICE_W-1:0] book_price [SLOTS];
  logic [lobm_pkg::QTY_W-1:0]   book_qty   [SLOTS];
  logic [lobm_pkg::OWNER_W-1:0] book_owner [SLOTS];
  logic [lobm_pkg::OID_W-1:0]   book_oid   [SLOTS];
  logic [lobm_pkg::ARR_W-1:0]   book_arr   [SLOTS];
  logic [lobm_pkg::ARR_W-1:0]   arrival_cnt;
  logic [lobm_pkg::TICK_W-1:0]  tick_reg;

  order_t         pending_orders[$];
  lobm_pkg::rep_t expected_reports[$];

  int errors = 0;
  int orders_taken = 0;
  int reports_seen = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  logic hold_go = 1'b0;
  logic hold_active = 1'b0;

  function automatic logic [lobm_pkg::ARR_W-1:0] age_of(int i);
    return arrival_cnt - book_arr[i];
  endfunction

  // Best slot of one side; ties go to the oldest or the newest order.
  function automatic int best_slot(logic sd, bit oldest);
    int b;
    bit better;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!book_valid[i] || book_side[i] != sd) continue;
      if (b < 0) begin
        b = i;
        continue;
      end
      if (book_price[i] != book_price[b])
        better = (sd == 1'b0) ? book_price[i] > book_price[b] : book_price[i] < book_price[b];
      else
        better = oldest ? age_of(i) > age_of(b) : age_of(i) < age_of(b);
      if (better) b = i;
    end
    return b;
  endfunction

  task automatic push_report(logic kind, logic [15:0] owner, logic [31:0] oid,
                             logic [1:0] action, logic side,
                             logic [lobm_pkg::PRICE_W-1:0] price,
                             logic [lobm_pkg::QTY_W-1:0] q, logic [lobm_pkg::QTY_W-1:0] ex,
                             logic [lobm_pkg::QTY_W-1:0] rs, logic [lobm_pkg::QTY_W-1:0] cn,
                             logic [62:0] t);
    lobm_pkg::rep_t r;
    r.kind = kind; r.owner = owner; r.oid = oid; r.action = action; r.side = side;
    r.price = price; r.qty = q; r.executed = ex; r.resting = rs; r.cancelled = cn;
    r.rtime = t; r.last = 1'b0;
    expected_reports.insert(expected_reports.size(), r);
  endtask

  // Aggressor takes from the opposite side at price-time priority.
  task automatic sweep_book(order_t o, logic [1:0] action, bit has_lim,
                            output logic [lobm_pkg::QTY_W-1:0] executed);
    logic [lobm_pkg::QTY_W-1:0] remaining;
    logic [lobm_pkg::QTY_W-1:0] f;
    logic [lobm_pkg::PRICE_W-1:0] p;
    int b;
    remaining = o.qty[lobm_pkg::QTY_W-1:0];
    executed = '0;
    while (remaining > 0) begin
      b = best_slot(~o.side, 1'b1);
      if (b < 0) break;
      p = book_price[b];
      if (has_lim && ((o.side == 1'b0) ? (p > o.price) : (p < o.price))) break;
      f = (remaining < book_qty[b]) ? remaining : book_qty[b];
      remaining -= f;
      book_qty[b] -= f;
      executed += f;
      if (book_owner[b] != 0)
        push_report(lobm_pkg::KIND_FILL, book_owner[b], book_oid[b], lobm_pkg::FUNC_LIMIT,
                    book_side[b], p, f, '0, '0, '0, o.ts);
      if (o.owner != 0)
        push_report(lobm_pkg::KIND_FILL, o.owner, o.oid, action, o.side, p, f, '0, '0, '0,
                    o.ts);
      if (book_qty[b] == 0) book_valid[b] = 1'b0;
    end
  endtask

  // Applies one accepted message to the predicted book and queues its reports.
  task automatic apply_order(order_t o);
    logic [lobm_pkg::QTY_W-1:0] req, ex, rs, remaining, r;
    logic [20:0] canc;
    longint step, target;
    int start_n, b, n;
    req = '0; ex = '0; rs = '0; canc = '0;
    start_n = expected_reports.size();
    if (o.qty > 0) req = o.qty[lobm_pkg::QTY_W-1:0];
    case (o.func)
      lobm_pkg::FUNC_LIMIT: begin
        if (o.qty > 0 && o.price > 0) begin
          sweep_book(o, lobm_pkg::FUNC_LIMIT, 1'b1, ex);
          remaining = o.qty[lobm_pkg::QTY_W-1:0] - ex;
          if (remaining > 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (book_valid[i]) continue;
              book_valid[i] = 1'b1;
              book_side[i] = o.side;
              book_price[i] = o.price[lobm_pkg::PRICE_W-1:0];
              book_qty[i] = remaining;
              book_owner[i] = o.owner;
              book_oid[i] = o.oid;
              book_arr[i] = arrival_cnt;
              arrival_cnt++;
              rs = remaining;
              break;
            end
          end
        end
      end
      lobm_pkg::FUNC_MARKET: begin
        if (o.qty > 0) sweep_book(o, lobm_pkg::FUNC_MARKET, 1'b0, ex);
      end
      lobm_pkg::FUNC_COWNER: begin
        req = '0;
        if (o.owner != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (book_valid[i] && book_owner[i] == o.owner) begin
              canc += book_qty[i];
              if (canc > lobm_pkg::QTY_MAX) canc = {1'b0, lobm_pkg::QTY_MAX};
              book_valid[i] = 1'b0;
            end
          end
        end
      end
      default: begin
        b = (o.qty > 0 && o.lvl_off >= 0) ? best_slot(o.side, 1'b1) : -1;
        if (b >= 0) begin
          step = longint'(o.lvl_off) * longint'((tick_reg == 0) ? 16'd1 : tick_reg);
          target = (o.side == 1'b0) ? longint'(book_price[b]) - step
                                    : longint'(book_price[b]) + step;
          remaining = o.qty[lobm_pkg::QTY_W-1:0];
          while (remaining > 0) begin
            n = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (!book_valid[i] || book_side[i] != o.side) continue;
              if (longint'(book_price[i]) != target) continue;
              if (n < 0 || age_of(i) < age_of(n)) n = i;
            end
            if (n < 0) break;
            r = (remaining < book_qty[n]) ? remaining : book_qty[n];
            book_qty[n] -= r;
            remaining -= r;
            canc += r;
            if (book_qty[n] == 0) book_valid[n] = 1'b0;
          end
        end
      end
    endcase
    if (o.owner != 0 && o.inst)
      push_report(lobm_pkg::KIND_RESULT, o.owner, o.oid, o.func, o.side, '0, req, ex, rs,
                  canc[lobm_pkg::QTY_W-1:0], o.ts);
    if (expected_reports.size() > start_n)
      expected_reports[expected_reports.size()-1].last = 1'b1;
  endtask

  task automatic add_order(logic [1:0] func, logic side, int qty, int price,
                           int owner, logic [31:0] oid, logic inst, int lvl_off,
                           logic [62:0] ts);
    order_t o;
    o.func = func; o.side = side; o.qty = 21'(qty); o.price = 24'(price);
    o.owner = 16'(owner); o.oid = oid; o.inst = inst; o.lvl_off = 8'(lvl_off); o.ts = ts;
    pending_orders.insert(pending_orders.size(), o);
  endtask

  // Mostly well-formed traffic in a narrow band so orders cross and levels line up.
  task automatic add_random_order(int base, int step);
    order_t o;
    int pick;
    pick = int'($urandom_range(99));
    o.side = 1'($urandom_range(1));
    o.oid = $urandom;
    o.ts = 63'({$urandom, $urandom});
    o.inst = 1'($urandom_range(1));
    o.owner = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    if ($urandom_range(19) == 0) o.owner = 16'($urandom);
    o.price = 24'(base + (int'($urandom_range(12)) - 6) * step);
    o.qty = 21'($urandom_range(1, 60));
    o.lvl_off = 8'($urandom_range(4));
    if (pick < 68) begin
      o.func = lobm_pkg::FUNC_LIMIT;
    end else if (pick < 83) begin
      o.func = lobm_pkg::FUNC_MARKET;
      o.qty = 21'($urandom_range(1, 150));
    end else if (pick < 92) begin
      o.func = lobm_pkg::FUNC_CDIST;
      if ($urandom_range(7) == 0) o.lvl_off = 8'($urandom);
    end else if (pick < 96) begin
      o.func = lobm_pkg::FUNC_COWNER;
    end else begin
      // Noise: any value of any field.
      o.func = 2'($urandom);
      o.qty = 21'($urandom);
      o.price = 24'($urandom);
      o.lvl_off = 8'($urandom);
      o.owner = 16'($urandom);
    end
    pending_orders.insert(pending_orders.size(), o);
  endtask

  task automatic write_tick(logic [lobm_pkg::TICK_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    tick_reg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_orders.size() != 0 || expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Order driver: offers the head of the pending queue, retires it on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_bus.valid <= 1'b0;
    end else begin
      if (ord_bus.valid && ord_bus.ready) begin
        apply_order(pending_orders[0]);
        pending_orders.delete(0);
        orders_taken++;
      end
      if (!ord_bus.valid || ord_bus.ready) begin
        if (pending_orders.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ord_bus.valid <= 1'b1;
          ord_bus.func <= pending_orders[0].func;
          ord_bus.side <= pending_orders[0].side;
          ord_bus.quantity <= pending_orders[0].qty;
          ord_bus.price <= pending_orders[0].price;
          ord_bus.owner <= pending_orders[0].owner;
          ord_bus.msg_seq <= pending_orders[0].oid;
          ord_bus.institutional <= pending_orders[0].inst;
          ord_bus.distance <= pending_orders[0].lvl_off;
          ord_bus.timestamp <= pending_orders[0].ts;
        end else begin
          ord_bus.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    ord_bus.func = '0; ord_bus.side = 1'b0; ord_bus.quantity = '0; ord_bus.price = '0;
    ord_bus.owner = '0; ord_bus.msg_seq = '0; ord_bus.institutional = 1'b0;
    ord_bus.distance = '0; ord_bus.timestamp = '0;
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Report monitor: compares each word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    lobm_pkg::rep_t e;
    if (!rst_ni) begin
      rep_bus.ready <= 1'b0;
    end else begin
      if (rep_bus.valid && rep_bus.ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $error("report word with no prediction pending");
          errors++;
        end else begin
          e = expected_reports[0];
          expected_reports.delete(0);
          check_field("report_kind", e.kind, rep_bus.report_kind);
          check_field("rep_owner", e.owner, rep_bus.rep_owner);
          check_field("rep_order_id", e.oid, rep_bus.rep_order_id);
          check_field("rep_action", e.action, rep_bus.rep_action);
          check_field("rep_side", e.side, rep_bus.rep_side);
          check_field("fill_price", e.price, rep_bus.fill_price);
          check_field("fill_or_requested_qty", e.qty, rep_bus.fill_or_requested_qty);
          check_field("executed_qty", e.executed, rep_bus.executed_qty);
          check_field("resting_qty", e.resting, rep_bus.resting_qty);
          check_field("cancelled_qty", e.cancelled, rep_bus.cancelled_qty);
          check_field("rep_time", e.rtime, rep_bus.rep_time);
          check_field("last", e.last, rep_bus.last);
        end
      end
      rep_bus.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  always begin
    @(posedge hold_go);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (700) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((ord_bus.valid && ord_bus.ready) || (rep_bus.valid && rep_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Sequence: reset, directed orders, then four random phases, each of which writes a tick size.
  initial begin
    for (int i = 0; i < SLOTS; i++) book_valid[i] = 1'b0;
    arrival_cnt = '0;
    tick_reg = 16'd1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_tick(16'd1);

    // Directed part: field extremes, every function and the corner cases.
    add_order(lobm_pkg::FUNC_LIMIT, 1'b0, 10, 100, 1, 32'd1, 1'b1, 0, 63'd5);
    add_order(lobm_pkg::FUNC_LIMIT, 1'b0, 1048575, 8388607, 65535, 32'hFFFF_FFFF, 1'b1, 0,
              '1);
    add_order(lobm_pkg::FUNC_MARKET, 1'b1, 1048575, 0, 2, 32'd3, 1'b1, 0, 63'd7);
    add_order(lobm_pkg::FUNC_LIMIT, 1'b0, 0, 100, 1, 32'd4, 1'b1, 0, 63'd8);
    add_order(lobm_pkg::FUNC_LIMIT, 1'b1, -1048576, -8388608, 1, 32'd5, 1'b1, -128, 63'd9);
    add_order(lobm_pkg::FUNC_LIMIT, 1'b1, 20, 0, 1, 32'd6, 1'b1, 0, 63'd10);
    add_order(lobm_pkg::FUNC_MARKET, 1'b0, 30, 0, 3, 32'd7, 1'b1, 0, 63'd11);
    add_order(lobm_pkg::FUNC_LIMIT, 1'b1, 5, 100, 0, 32'd8, 1'b1, 0, 63'd12);
    add_order(lobm_pkg::FUNC_COWNER, 1'b0, 0, 0, 0, 32'd9, 1'b1, 0, 63'd13);
    add_order(lobm_pkg::FUNC_CDIST, 1'b0, 10, 0, 1, 32'd10, 1'b1, -1, 63'd14);
    add_order(lobm_pkg::FUNC_CDIST, 1'b0, 10, 0, 1, 32'd11, 1'b1, 127, 63'd15);
    add_order(lobm_pkg::FUNC_CDIST, 1'b0, 3, 0, 1, 32'd12, 1'b1, 0, 63'd16);
    add_order(lobm_pkg::FUNC_COWNER, 1'b1, 0, 0, 1, 32'd13, 1'b1, 0, 63'd17);
    // Seventeen resting sells: the last finds the book full.
    for (int i = 0; i <= SLOTS; i++)
      add_order(lobm_pkg::FUNC_LIMIT, 1'b1, 3, 200 + i, 4, 32'd100 + i, 1'b1, 0, 63'd20 + i);
    add_order(lobm_pkg::FUNC_MARKET, 1'b0, 1048575, 0, 5, 32'd200, 1'b1, 0, 63'd40);
    add_order(lobm_pkg::FUNC_CDIST, 1'b1, 5, 0, 5, 32'd201, 1'b0, 2, 63'd41);
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      int step;
      step = (ph == 1) ? 65535 : (ph == 2) ? 7 : 1;
      write_tick(16'(step));
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 56 : 35) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 56 : 35) : 0;
      if (ph == 2) hold_go = 1'b1;
      for (int k = 0; k < RAND_ITEMS / 2; k++) add_random_order(4000000, step);
      if (ph == 1) begin
        // Sender pauses until every predicted word has come out.
        while (pending_orders.size() != 0 || expected_reports.size() != 0) @(posedge clk_i);
      end
      for (int k = RAND_ITEMS / 2; k < RAND_ITEMS; k++) add_random_order(4000000, step);
      drain_all();
    end

    $display("Run covered %0d order messages and %0d report words", orders_taken,
             reports_seen);
    $display("over four idle/stall mixes and tick sizes 1, 7 and 65535.");
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/lobm_pkg.sv
src/lobm_if.sv
src/limit_order_book_matcher_top.sv
tb/limit_order_book_matcher_top_tb.sv
